// ----- sv/pn2d_pkg.sv -----
// ============================================================================
// pn2d_pkg
// Shared types, constants and lookup tables for the 2D gradient noise pipeline.
// ============================================================================
package pn2d_pkg;

    // Fraction width used inside the datapath (Q.16)
    localparam int QB = 16;

    // Number of register stages from input beat to output register
    localparam int NSTG = 9;

    // Rounding offset for a Q.32 -> Q.16 product (one half)
    localparam int ROUND_HALF = 32768;

    // Fade polynomial constants in Q.16
    localparam int FADE_C15 = 983040;
    localparam int FADE_C10 = 655360;

    // Output clamp bound (1.0 in Q1.16)
    localparam int NOISE_MAX = 65536;

    typedef logic [3:0]         t_idx;
    typedef logic [15:0]        t_frac;
    typedef logic signed [17:0] t_grad;
    typedef logic signed [17:0] t_ofs;
    typedef logic signed [19:0] t_dot;
    typedef logic [16:0]        t_wgt;
    typedef logic signed [17:0] t_noise;

    // Gradient component magnitudes in Q1.16
    localparam t_grad G_ONE = 18'sd65536;
    localparam t_grad G_C22 = 18'sd60547;
    localparam t_grad G_S22 = 18'sd25080;
    localparam t_grad G_C45 = 18'sd46341;

    // Fixed 16-entry permutation
    function automatic t_idx perm16(input t_idx i);
        t_idx r;
        unique case (i)
            4'd0:  r = 4'd6;
            4'd1:  r = 4'd4;
            4'd2:  r = 4'd12;
            4'd3:  r = 4'd7;
            4'd4:  r = 4'd10;
            4'd5:  r = 4'd1;
            4'd6:  r = 4'd3;
            4'd7:  r = 4'd9;
            4'd8:  r = 4'd0;
            4'd9:  r = 4'd14;
            4'd10: r = 4'd13;
            4'd11: r = 4'd5;
            4'd12: r = 4'd15;
            4'd13: r = 4'd8;
            4'd14: r = 4'd2;
            4'd15: r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Gradient x component, 22.5 degree steps
    function automatic t_grad grad_x(input t_idx i);
        t_grad r;
        unique case (i)
            4'd0:  r = G_ONE;
            4'd1:  r = G_C22;
            4'd2:  r = G_C45;
            4'd3:  r = G_S22;
            4'd4:  r = '0;
            4'd5:  r = -G_S22;
            4'd6:  r = -G_C45;
            4'd7:  r = -G_C22;
            4'd8:  r = -G_ONE;
            4'd9:  r = -G_C22;
            4'd10: r = -G_C45;
            4'd11: r = -G_S22;
            4'd12: r = '0;
            4'd13: r = G_S22;
            4'd14: r = G_C45;
            4'd15: r = G_C22;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Gradient y component, 22.5 degree steps
    function automatic t_grad grad_y(input t_idx i);
        t_grad r;
        unique case (i)
            4'd0:  r = '0;
            4'd1:  r = G_S22;
            4'd2:  r = G_C45;
            4'd3:  r = G_C22;
            4'd4:  r = G_ONE;
            4'd5:  r = G_C22;
            4'd6:  r = G_C45;
            4'd7:  r = G_S22;
            4'd8:  r = '0;
            4'd9:  r = -G_S22;
            4'd10: r = -G_C45;
            4'd11: r = -G_C22;
            4'd12: r = -G_ONE;
            4'd13: r = -G_C22;
            4'd14: r = -G_C45;
            4'd15: r = -G_S22;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/pn2d_front.sv -----
// ============================================================================
// pn2d_front
// Input stage: split coordinates into cell and fraction, pick corner gradients.
// ============================================================================
module pn2d_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [31:0]        i_x_coord,
    input  logic signed [31:0]        i_y_coord,
    output pn2d_pkg::t_frac           o_rx,
    output pn2d_pkg::t_frac           o_ry,
    output pn2d_pkg::t_idx [3:0]      o_gi
);

    pn2d_pkg::t_frac n_rx;
    pn2d_pkg::t_frac n_ry;
    pn2d_pkg::t_idx  cx;
    pn2d_pkg::t_idx  cy;
    pn2d_pkg::t_idx  cx1;
    pn2d_pkg::t_idx  cy1;
    pn2d_pkg::t_idx  py0;
    pn2d_pkg::t_idx  py1;
    pn2d_pkg::t_idx  a00;
    pn2d_pkg::t_idx  a10;
    pn2d_pkg::t_idx  a01;
    pn2d_pkg::t_idx  a11;
    pn2d_pkg::t_idx [3:0] n_gi;

    pn2d_pkg::t_frac      r_rx;
    pn2d_pkg::t_frac      r_ry;
    pn2d_pkg::t_idx [3:0] r_gi;

    // Bring the fraction to Q.16: drop extra low bits or pad with zeros
    generate
        if (FRAC_BITS >= pn2d_pkg::QB) begin : g_frac_trunc
            assign n_rx = i_x_coord[FRAC_BITS-1 -: pn2d_pkg::QB];
            assign n_ry = i_y_coord[FRAC_BITS-1 -: pn2d_pkg::QB];
        end else begin : g_frac_pad
            assign n_rx = {i_x_coord[FRAC_BITS-1:0], {(pn2d_pkg::QB-FRAC_BITS){1'b0}}};
            assign n_ry = {i_y_coord[FRAC_BITS-1:0], {(pn2d_pkg::QB-FRAC_BITS){1'b0}}};
        end
    endgenerate

    // Cell index wraps mod 16; 4-bit sums wrap on their own
    always_comb begin
        cx      = i_x_coord[FRAC_BITS +: 4];
        cy      = i_y_coord[FRAC_BITS +: 4];
        cx1     = cx + 4'd1;
        cy1     = cy + 4'd1;
        py0     = pn2d_pkg::perm16(cy);
        py1     = pn2d_pkg::perm16(cy1);
        a00     = cx + py0;
        a10     = cx1 + py0;
        a01     = cx + py1;
        a11     = cx1 + py1;
        n_gi[0] = pn2d_pkg::perm16(a00);
        n_gi[1] = pn2d_pkg::perm16(a10);
        n_gi[2] = pn2d_pkg::perm16(a01);
        n_gi[3] = pn2d_pkg::perm16(a11);
    end

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_gi <= n_gi;
        end
    end

    assign o_rx = r_rx;
    assign o_ry = r_ry;
    assign o_gi = r_gi;

endmodule

// ----- sv/pn2d_dot.sv -----
// ============================================================================
// pn2d_dot
// Corner dot product: gradient times offset, rounded to Q.16, delay-matched.
// ============================================================================
module pn2d_dot (
    input  logic              i_clk,
    input  logic [3:0]        i_en,
    input  pn2d_pkg::t_idx    i_gi,
    input  pn2d_pkg::t_ofs    i_dx,
    input  pn2d_pkg::t_ofs    i_dy,
    output pn2d_pkg::t_dot    o_dot
);

    pn2d_pkg::t_grad          gx;
    pn2d_pkg::t_grad          gy;
    logic signed [35:0]       n_px;
    logic signed [35:0]       n_py;
    logic signed [37:0]       dsum;
    pn2d_pkg::t_dot           n_dot;

    logic signed [35:0]       r_px;
    logic signed [35:0]       r_py;
    pn2d_pkg::t_dot           r_dot;
    pn2d_pkg::t_dot           r_dot_d1;
    pn2d_pkg::t_dot           r_dot_d2;

    // Look up gradient and multiply by corner offset
    always_comb begin
        gx   = pn2d_pkg::grad_x(i_gi);
        gy   = pn2d_pkg::grad_y(i_gi);
        n_px = gx * i_dx;
        n_py = gy * i_dy;
    end

    // Sum in Q.32 and round once, half up
    always_comb begin
        dsum  = 38'(r_px) + 38'(r_py) + 38'(pn2d_pkg::ROUND_HALF);
        n_dot = dsum[35:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (i_en[1]) begin
            r_dot <= n_dot;
        end
        // Delay to line up with the fade weights
        if (i_en[2]) begin
            r_dot_d1 <= r_dot;
        end
        if (i_en[3]) begin
            r_dot_d2 <= r_dot_d1;
        end
    end

    assign o_dot = r_dot_d2;

endmodule

// ----- sv/pn2d_fade.sv -----
// ============================================================================
// pn2d_fade
// Fade curve 6t^5 - 15t^4 + 10t^3 in Q.16, products split across pipeline stages.
// ============================================================================
module pn2d_fade (
    input  logic              i_clk,
    input  logic [3:0]        i_en,
    input  pn2d_pkg::t_frac   i_t,
    output pn2d_pkg::t_wgt    o_w
);

    logic signed [16:0]       ts;
    logic signed [20:0]       poly;
    logic signed [37:0]       n_ta;
    logic [31:0]              n_tt;
    logic signed [38:0]       sa;
    logic signed [20:0]       pq;
    logic signed [20:0]       pfull;
    logic [32:0]              s2;
    logic [15:0]              t2;
    logic [19:0]              n_p;
    logic [31:0]              n_t3p;
    logic [32:0]              s3;
    logic [15:0]              t3;
    logic [35:0]              n_fp;
    logic [36:0]              s4;
    pn2d_pkg::t_wgt           n_w;

    logic signed [37:0]       r_ta;
    logic [31:0]              r_tt;
    pn2d_pkg::t_frac          r_t;
    logic [19:0]              r_p;
    logic [31:0]              r_t3p;
    logic [35:0]              r_fp;
    pn2d_pkg::t_wgt           r_w;

    // Stage 2: t*(6t - 15) and t*t
    always_comb begin
        ts   = signed'({1'b0, i_t});
        poly = 21'(ts) * 21'sd6 - 21'(pn2d_pkg::FADE_C15);
        n_ta = ts * poly;
        n_tt = i_t * i_t;
    end

    // Stage 3: round, add 10, then t2*t
    always_comb begin
        sa    = 39'(r_ta) + 39'(pn2d_pkg::ROUND_HALF);
        pq    = sa[36:16];
        pfull = pq + 21'(pn2d_pkg::FADE_C10);
        n_p   = pfull[19:0];
        s2    = 33'(r_tt) + 33'(pn2d_pkg::ROUND_HALF);
        t2    = s2[31:16];
        n_t3p = t2 * r_t;
    end

    // Stage 4: round t3, then t3*p
    always_comb begin
        s3   = 33'(r_t3p) + 33'(pn2d_pkg::ROUND_HALF);
        t3   = s3[31:16];
        n_fp = t3 * r_p;
    end

    // Stage 5: round to the weight
    always_comb begin
        s4  = 37'(r_fp) + 37'(pn2d_pkg::ROUND_HALF);
        n_w = s4[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ta <= n_ta;
            r_tt <= n_tt;
            r_t  <= i_t;
        end
        if (i_en[1]) begin
            r_p   <= n_p;
            r_t3p <= n_t3p;
        end
        if (i_en[2]) begin
            r_fp <= n_fp;
        end
        if (i_en[3]) begin
            r_w <= n_w;
        end
    end

    assign o_w = r_w;

endmodule

// ----- sv/pn2d_mix.sv -----
// ============================================================================
// pn2d_mix
// Bilinear blend: x blend on both rows, then y blend, clamp, output register.
// ============================================================================
module pn2d_mix (
    input  logic              i_clk,
    input  logic [3:0]        i_en,
    input  pn2d_pkg::t_wgt    i_u,
    input  pn2d_pkg::t_wgt    i_v,
    input  pn2d_pkg::t_dot    i_d00,
    input  pn2d_pkg::t_dot    i_d10,
    input  pn2d_pkg::t_dot    i_d01,
    input  pn2d_pkg::t_dot    i_d11,
    output pn2d_pkg::t_noise  o_noise
);

    logic signed [17:0]       us;
    logic signed [20:0]       df0;
    logic signed [20:0]       df1;
    logic signed [38:0]       n_m0;
    logic signed [38:0]       n_m1;
    logic signed [39:0]       s0;
    logic signed [39:0]       s1;
    logic signed [20:0]       rd0;
    logic signed [20:0]       rd1;
    logic signed [20:0]       n_nx0;
    logic signed [20:0]       n_nx1;
    logic signed [17:0]       vs;
    logic signed [21:0]       dfy;
    logic signed [39:0]       n_my;
    logic signed [40:0]       sy;
    logic signed [21:0]       rdy;
    logic signed [21:0]       rsum;
    pn2d_pkg::t_noise         n_noise;

    logic signed [38:0]       r_m0;
    logic signed [38:0]       r_m1;
    pn2d_pkg::t_dot           r_d00;
    pn2d_pkg::t_dot           r_d01;
    pn2d_pkg::t_wgt           r_v6;
    logic signed [20:0]       r_nx0;
    logic signed [20:0]       r_nx1;
    pn2d_pkg::t_wgt           r_v7;
    logic signed [39:0]       r_my;
    logic signed [20:0]       r_nx0_d;
    pn2d_pkg::t_noise         r_noise;

    // Stage 6: u * (b - a) on both rows
    always_comb begin
        us   = signed'({1'b0, i_u});
        df0  = 21'(i_d10) - 21'(i_d00);
        df1  = 21'(i_d11) - 21'(i_d01);
        n_m0 = us * df0;
        n_m1 = us * df1;
    end

    // Stage 7: a + round(product)
    always_comb begin
        s0    = 40'(r_m0) + 40'(pn2d_pkg::ROUND_HALF);
        s1    = 40'(r_m1) + 40'(pn2d_pkg::ROUND_HALF);
        rd0   = s0[36:16];
        rd1   = s1[36:16];
        n_nx0 = 21'(r_d00) + rd0;
        n_nx1 = 21'(r_d01) + rd1;
    end

    // Stage 8: v * (row1 - row0)
    always_comb begin
        vs   = signed'({1'b0, r_v7});
        dfy  = 22'(r_nx1) - 22'(r_nx0);
        n_my = vs * dfy;
    end

    // Stage 9: final add and clamp to [-1, 1]
    always_comb begin
        sy   = 41'(r_my) + 41'(pn2d_pkg::ROUND_HALF);
        rdy  = sy[37:16];
        rsum = 22'(r_nx0_d) + rdy;
        priority if (rsum > 22'(pn2d_pkg::NOISE_MAX)) begin
            n_noise = 18'(pn2d_pkg::NOISE_MAX);
        end else if (rsum < -22'(pn2d_pkg::NOISE_MAX)) begin
            n_noise = -18'(pn2d_pkg::NOISE_MAX);
        end else begin
            n_noise = rsum[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m0  <= n_m0;
            r_m1  <= n_m1;
            r_d00 <= i_d00;
            r_d01 <= i_d01;
            r_v6  <= i_v;
        end
        if (i_en[1]) begin
            r_nx0 <= n_nx0;
            r_nx1 <= n_nx1;
            r_v7  <= r_v6;
        end
        if (i_en[2]) begin
            r_my    <= n_my;
            r_nx0_d <= r_nx0;
        end
        if (i_en[3]) begin
            r_noise <= n_noise;
        end
    end

    assign o_noise = r_noise;

endmodule

// ----- sv/perlin_noise_2d_top.sv -----
// ============================================================================
// perlin_noise_2d_top
// 2D gradient noise: one Q16.16 point in, one Q1.16 noise value out.
//
//   channel | valid    | stall    | payload
//   --------+----------+----------+-------------------------------
//   input   | i_valid  | o_stall  | i_x_coord, i_y_coord (Q16.16)
//   output  | o_valid  | i_stall  | o_noise_value (Q1.16)
//
// One point per clock while the output is not stalled; nine register stages
// lie between input beat and output beat (front, four product and round stages
// shared by the dot products and fade weights, four blend stages). Each
// stage holds its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up under output stall.
// Reset clears the valid bits only; no clearing pass is needed.
// ============================================================================
module perlin_noise_2d_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_x_coord,
    input  logic signed [31:0]  i_y_coord,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [17:0]  o_noise_value
);

    logic [pn2d_pkg::NSTG-1:0]  r_vld;
    logic [pn2d_pkg::NSTG-1:0]  n_vld;
    logic [pn2d_pkg::NSTG-1:0]  stg_en;

    pn2d_pkg::t_frac            rx;
    pn2d_pkg::t_frac            ry;
    pn2d_pkg::t_idx [3:0]       gi;
    pn2d_pkg::t_ofs             dx0;
    pn2d_pkg::t_ofs             dx1;
    pn2d_pkg::t_ofs             dy0;
    pn2d_pkg::t_ofs             dy1;
    pn2d_pkg::t_dot             d00;
    pn2d_pkg::t_dot             d10;
    pn2d_pkg::t_dot             d01;
    pn2d_pkg::t_dot             d11;
    pn2d_pkg::t_wgt             wu;
    pn2d_pkg::t_wgt             wv;
    pn2d_pkg::t_noise           noise;

    // Stage enables: a stage moves when empty or when its successor moves
    always_comb begin
        stg_en[pn2d_pkg::NSTG-1] = !r_vld[pn2d_pkg::NSTG-1] || !i_stall;
        for (int k = pn2d_pkg::NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    // Advance valid bits with their stages
    always_comb begin
        n_vld = r_vld;
        if (stg_en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < pn2d_pkg::NSTG; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !stg_en[0];
    assign o_valid = r_vld[pn2d_pkg::NSTG-1];

    // Split and gradient selection
    pn2d_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_en      (stg_en[0]),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_rx      (rx),
        .o_ry      (ry),
        .o_gi      (gi)
    );

    // Corner offsets: the far corner sits at fraction minus one
    assign dx0 = signed'({2'b00, rx});
    assign dx1 = signed'({2'b11, rx});
    assign dy0 = signed'({2'b00, ry});
    assign dy1 = signed'({2'b11, ry});

    pn2d_dot u_dot00 (
        .i_clk (i_clk),
        .i_en  (stg_en[4:1]),
        .i_gi  (gi[0]),
        .i_dx  (dx0),
        .i_dy  (dy0),
        .o_dot (d00)
    );

    pn2d_dot u_dot10 (
        .i_clk (i_clk),
        .i_en  (stg_en[4:1]),
        .i_gi  (gi[1]),
        .i_dx  (dx1),
        .i_dy  (dy0),
        .o_dot (d10)
    );

    pn2d_dot u_dot01 (
        .i_clk (i_clk),
        .i_en  (stg_en[4:1]),
        .i_gi  (gi[2]),
        .i_dx  (dx0),
        .i_dy  (dy1),
        .o_dot (d01)
    );

    pn2d_dot u_dot11 (
        .i_clk (i_clk),
        .i_en  (stg_en[4:1]),
        .i_gi  (gi[3]),
        .i_dx  (dx1),
        .i_dy  (dy1),
        .o_dot (d11)
    );

    pn2d_fade u_fade_x (
        .i_clk (i_clk),
        .i_en  (stg_en[4:1]),
        .i_t   (rx),
        .o_w   (wu)
    );

    pn2d_fade u_fade_y (
        .i_clk (i_clk),
        .i_en  (stg_en[4:1]),
        .i_t   (ry),
        .o_w   (wv)
    );

    pn2d_mix u_mix (
        .i_clk   (i_clk),
        .i_en    (stg_en[8:5]),
        .i_u     (wu),
        .i_v     (wv),
        .i_d00   (d00),
        .i_d10   (d10),
        .i_d01   (d01),
        .i_d11   (d11),
        .o_noise (noise)
    );

    assign o_noise_value = noise;

endmodule

// ----- sv/pn2d_checker.sv -----
// ============================================================================
// pn2d_checker
// Port-level checks for the 2D gradient noise pipeline.
// ============================================================================
module pn2d_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_stall,
    input  logic signed [31:0]  i_x_coord,
    input  logic signed [31:0]  i_y_coord,
    input  logic                o_valid,
    input  logic                i_stall,
    input  logic signed [17:0]  o_noise_value
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An empty or moving output lets the whole pipeline advance
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output side is free");

    // Noise stays within [-1, 1]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_noise_value <= 18'sd65536) && (o_noise_value >= -18'sd65536))
        else $error("noise value out of range");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_noise_value)))
        else $error("stalled output beat changed");

    // A stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_x_coord) && $stable(i_y_coord)))
        else $error("stalled input beat changed");

endmodule

bind perlin_noise_2d_top pn2d_checker u_pn2d_checker (.*);
